// ----- hdl/page_framebuffer_draw_engine_macros.svh -----
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_MACROS_SVH

// condition holds on the same edge
`define PFDE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition holds on the next edge
`define PFDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/pfde_pkg.sv -----
`default_nettype none

package pfde_pkg;

  // full-range byte address: column plus page offset, before the store bound
  localparam int PIX_AW = 13;

  localparam logic [2:0] MODE_PIXEL  = 3'd0;
  localparam logic [2:0] MODE_FILL   = 3'd1;
  localparam logic [2:0] MODE_GLYPH  = 3'd2;
  localparam logic [2:0] MODE_CURSOR = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;

  localparam logic [1:0] REG_DISPLAY_WIDTH  = 2'd0;
  localparam logic [1:0] REG_DISPLAY_HEIGHT = 2'd1;
  localparam logic [1:0] REG_FONT_WIDTH     = 2'd2;
  localparam logic [1:0] REG_FONT_HEIGHT    = 2'd3;

  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [7:0] BYTE_ZERO = 8'h00;

  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic        color;
    logic [15:0] row_bits;
    logic [4:0]  row_index;
    logic        last_row;
    logic [9:0]  read_index;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       accepted;
  } rsp_t;

  typedef struct packed {
    logic [7:0] display_width;
    logic [6:0] display_height;
    logic [4:0] font_width;
    logic [5:0] font_height;
  } cfg_t;

endpackage

`default_nettype wire

// ----- hdl/pfde_store.sv -----
`default_nettype none

module pfde_store #(
  parameter int STORE_BYTES = 1024,
  localparam int AW = $clog2(STORE_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [STORE_BYTES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ----- hdl/pfde_ctrl.sv -----
`default_nettype none
`include "page_framebuffer_draw_engine_macros.svh"

module pfde_ctrl
  import pfde_pkg::*;
#(
  parameter int STORE_BYTES = 1024,
  parameter int MAX_GLYPH_WIDTH = 16,
  localparam int AW = $clog2(STORE_BYTES)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cfg_t          cfg,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire req_t          req,
  output logic               rsp_valid,
  input  wire logic          rsp_ready,
  output rsp_t               rsp,
  output logic               mem_we,
  output logic      [AW-1:0] mem_addr,
  output logic      [7:0]    mem_wdata,
  input  wire logic [7:0]    mem_rdata
);

  localparam int GW = $clog2(MAX_GLYPH_WIDTH + 1);
  localparam logic [PIX_AW-1:0] STORE_LIM  = PIX_AW'(STORE_BYTES);
  localparam logic [PIX_AW-1:0] STORE_LAST = PIX_AW'(STORE_BYTES - 1);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_CALC  = 7'b0000100,
    S_FILL  = 7'b0001000,
    S_RD    = 7'b0010000,
    S_MOD   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t            state;
  req_t              req_q;
  logic [PIX_AW-1:0] addr;
  logic [PIX_AW-1:0] fill_end;
  logic [2:0]        bit_sel;
  logic [15:0]       glyph_bits;
  logic [GW-1:0]     pix_cnt;
  logic [GW-1:0]     pix_end;
  logic [7:0]        cursor_x;
  logic [7:0]        cursor_y;
  logic [7:0]        res_data;
  logic              res_ok;

  logic              is_glyph;
  logic [7:0]        x_sel;
  logic [7:0]        y_sel;
  logic [7:0]        glyph_y;
  logic [11:0]       page_off;
  logic [PIX_AW-1:0] base;
  logic              pix_ok;
  logic              glyph_fit;
  logic [14:0]       fill_area;
  logic [PIX_AW-1:0] fill_n;
  logic [GW-1:0]     glyph_n;
  logic              read_ok;
  logic [7:0]        mask;
  logic              pix_color;
  logic              mod_write;

  // address and range checks for the latched item
  always_comb begin
    is_glyph  = req_q.mode == MODE_GLYPH;
    glyph_y   = cursor_y + {3'b000, req_q.row_index};
    x_sel     = is_glyph ? cursor_x : req_q.pos_x;
    y_sel     = is_glyph ? glyph_y : req_q.pos_y;
    page_off  = 12'(y_sel[6:3]) * 12'(cfg.display_width);
    base      = {1'b0, page_off} + {5'b00000, x_sel};
    pix_ok    = (req_q.pos_x < cfg.display_width) &&
                (req_q.pos_y < {1'b0, cfg.display_height}) &&
                (base < STORE_LIM);
    glyph_fit = (({1'b0, cursor_x} + {4'b0000, cfg.font_width}) < {1'b0, cfg.display_width}) &&
                (({1'b0, cursor_y} + {3'b000, cfg.font_height}) <
                 {2'b00, cfg.display_height}) &&
                ({1'b0, req_q.row_index} < cfg.font_height);
    fill_area = 15'(cfg.display_width) * 15'(cfg.display_height);
    fill_n    = (PIX_AW'(fill_area[14:3]) > STORE_LIM) ? STORE_LIM : PIX_AW'(fill_area[14:3]);
    glyph_n   = (cfg.font_width > 5'(MAX_GLYPH_WIDTH)) ? GW'(MAX_GLYPH_WIDTH)
                                                         : GW'(cfg.font_width);
    read_ok   = PIX_AW'(req_q.read_index) < STORE_LIM;
  end

  // read-modify-write data path
  always_comb begin
    mask      = 8'b0000_0001 << bit_sel;
    pix_color = is_glyph ? (glyph_bits[15] ? req_q.color : ~req_q.color) : req_q.color;
    mod_write = ((req_q.mode == MODE_PIXEL) || is_glyph) && (addr < STORE_LIM);
    mem_addr  = addr[AW-1:0];
    mem_we    = 1'b0;
    mem_wdata = BYTE_ZERO;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = req_q.color ? BYTE_ONES : BYTE_ZERO;
      end
      S_MOD: begin
        mem_we    = mod_write;
        mem_wdata = pix_color ? (mem_rdata | mask) : (mem_rdata & ~mask);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign req_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      addr      <= '0;
      cursor_x  <= '0;
      cursor_y  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // a finishing item reloads the response register in the same cycle
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == STORE_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            req_q <= req;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          res_data   <= BYTE_ZERO;
          res_ok     <= 1'b0;
          bit_sel    <= y_sel[2:0];
          glyph_bits <= req_q.row_bits;
          pix_cnt    <= '0;
          pix_end    <= glyph_n;
          fill_end   <= fill_n;
          state      <= S_DONE;
          case (req_q.mode)
            MODE_PIXEL: begin
              addr <= base;
              if (pix_ok) begin
                res_ok <= 1'b1;
                state  <= S_RD;
              end
            end
            MODE_FILL: begin
              addr   <= '0;
              res_ok <= 1'b1;
              if (fill_n != '0) begin
                state <= S_FILL;
              end
            end
            MODE_GLYPH: begin
              addr <= base;
              if (glyph_fit) begin
                res_ok <= 1'b1;
                if (req_q.last_row) begin
                  cursor_x <= cursor_x + {3'b000, cfg.font_width};
                end
                if (glyph_n != '0) begin
                  state <= S_RD;
                end
              end
            end
            MODE_CURSOR: begin
              cursor_x <= req_q.pos_x;
              cursor_y <= req_q.pos_y;
              res_ok   <= 1'b1;
            end
            MODE_READ: begin
              addr <= PIX_AW'(req_q.read_index);
              if (read_ok) begin
                res_ok <= 1'b1;
                state  <= S_RD;
              end
            end
            default: begin
              res_ok <= 1'b0;
            end
          endcase
        end
        S_FILL: begin
          addr <= addr + 1'b1;
          if (addr + 1'b1 == fill_end) begin
            state <= S_DONE;
          end
        end
        S_RD: begin
          state <= S_MOD;
        end
        S_MOD: begin
          state <= S_DONE;
          case (req_q.mode)
            MODE_READ: begin
              res_data <= mem_rdata;
            end
            MODE_GLYPH: begin
              // consecutive columns of one page row are consecutive bytes
              glyph_bits <= {glyph_bits[14:0], 1'b0};
              pix_cnt    <= pix_cnt + 1'b1;
              addr       <= addr + 1'b1;
              if (pix_cnt + 1'b1 != pix_end) begin
                state <= S_RD;
              end
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.read_data <= res_data;
            rsp.accepted  <= res_ok;
            rsp_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PFDE_ASSERT_SAME(a_no_write_idle, clk, rst, state == S_IDLE, !mem_we, "store written while idle")
  `PFDE_ASSERT_SAME(a_read_no_write, clk, rst, (state == S_MOD) && (req_q.mode == MODE_READ), !mem_we, "read item wrote the store")
  `PFDE_ASSERT_NEXT(a_accept_calc, clk, rst, req_valid && req_ready, state == S_CALC, "accepted beat not decoded")
  `PFDE_ASSERT_SAME(a_fill_bound, clk, rst, state == S_FILL, addr < fill_end, "fill ran past its count")
  `PFDE_ASSERT_SAME(a_glyph_bound, clk, rst, (state == S_MOD) && is_glyph, pix_cnt < pix_end, "glyph column past its width")
  `PFDE_ASSERT_NEXT(a_clear_end, clk, rst, (state == S_CLEAR) && (addr == STORE_LAST), state == S_IDLE, "clearing pass overran")

endmodule

`default_nettype wire

// ----- hdl/page_framebuffer_draw_engine.sv -----
`default_nettype none

// Monochrome page-layout frame store with a pixel, fill and glyph-row draw engine.
// After reset the store is swept to zero one byte a cycle over all STORE_BYTES bytes,
// and no request beat is taken until that pass ends (register writes are taken).
// Every request gives one response beat. All work goes through one single-port
// store with a registered read, so items run one at a time: a pixel write or byte
// read goes through decode, read, modify/write and out, a cursor set or unused mode
// through decode and out, a fill through decode, width*height/8 byte writes (capped
// at STORE_BYTES, one byte written per cycle) and out, and a glyph row that fits
// through decode, a read and a write per column for min(font_width, MAX_GLYPH_WIDTH).
// A finished response sits in an output register, so the next request is taken
// while it waits for rsp_ready.

module page_framebuffer_draw_engine
  import pfde_pkg::*;
#(
  parameter int STORE_BYTES = 1024,
  parameter int MAX_GLYPH_WIDTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       req_valid,
  output logic            req_ready,
  input  wire req_t       req,
  output logic            rsp_valid,
  input  wire logic       rsp_ready,
  output rsp_t            rsp
);

  localparam int AW = $clog2(STORE_BYTES);

  cfg_t          cfg;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.display_width  <= 8'd128;
      cfg.display_height <= 7'd64;
      cfg.font_width     <= 5'd7;
      cfg.font_height    <= 6'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISPLAY_WIDTH:  cfg.display_width  <= cfg_wdata;
        REG_DISPLAY_HEIGHT: cfg.display_height <= cfg_wdata[6:0];
        REG_FONT_WIDTH:     cfg.font_width     <= cfg_wdata[4:0];
        REG_FONT_HEIGHT:    cfg.font_height    <= cfg_wdata[5:0];
        default: begin
          cfg <= cfg;
        end
      endcase
    end
  end

  pfde_ctrl #(
    .STORE_BYTES    (STORE_BYTES),
    .MAX_GLYPH_WIDTH(MAX_GLYPH_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .mem_we   (mem_we),
    .mem_addr (mem_addr),
    .mem_wdata(mem_wdata),
    .mem_rdata(mem_rdata)
  );

  pfde_store #(
    .STORE_BYTES(STORE_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

endmodule

`default_nettype wire

// ----- bench/page_framebuffer_draw_engine_test.sv -----
`default_nettype none

module page_framebuffer_draw_engine_test;
  import pfde_pkg::*;

  localparam int STORE_BYTES = 1024;
  localparam int MAX_GLYPH_W = 16;
  localparam int PHASE_ITEMS = 180;
  localparam int CYCLE_LIMIT = 10000000;
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

  typedef struct {
    bit         reg_write;
    logic [1:0] reg_idx;
    logic [7:0] reg_val;
    req_t       item;
    bit         typed;
    rsp_t       want;
  } plan_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;
  logic       req_valid = 1'b0;
  logic       req_ready;
  req_t       req = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  rsp_t       rsp;

  // mirror of the block: frame store, text cursor and registers
  logic [7:0] shadow_fb [STORE_BYTES];
  logic [7:0] shadow_cur_x;
  logic [7:0] shadow_cur_y;
  cfg_t       shadow_cfg;

  rsp_t       pending_rsp [$];
  plan_row_t  plan [$];
  int         err_count = 0;
  int         sent_items = 0;
  int         cycle_count = 0;
  bit         calm_tx = 1'b0;
  bit         calm_rx = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  page_framebuffer_draw_engine #(
    .STORE_BYTES(STORE_BYTES),
    .MAX_GLYPH_WIDTH(MAX_GLYPH_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  function automatic bit plot(input int unsigned x, input int unsigned y, input logic c);
    int unsigned addr;
    if (x >= shadow_cfg.display_width || y >= shadow_cfg.display_height) return 1'b0;
    addr = x + (y / 8) * shadow_cfg.display_width;
    if (addr >= STORE_BYTES) return 1'b0;
    shadow_fb[addr][y % 8] = c;
    return 1'b1;
  endfunction

  function automatic rsp_t apply_draw_item(input req_t it);
    rsp_t        r;
    int unsigned n;
    int unsigned w;
    int unsigned h;
    int unsigned fw;
    int unsigned fh;
    int unsigned j;
    r = '0;
    w = shadow_cfg.display_width;
    h = shadow_cfg.display_height;
    fw = shadow_cfg.font_width;
    fh = shadow_cfg.font_height;
    case (it.mode)
      MODE_PIXEL: begin
        r.accepted = plot(it.pos_x, it.pos_y, it.color);
      end
      MODE_FILL: begin
        n = (w * h) / 8;
        if (n > STORE_BYTES) n = STORE_BYTES;
        for (j = 0; j < n; j++) shadow_fb[j] = it.color ? BYTE_ONES : BYTE_ZERO;
        r.accepted = 1'b1;
      end
      MODE_GLYPH: begin
        if (shadow_cur_x + fw < w && shadow_cur_y + fh < h && it.row_index < fh) begin
          // columns past the widest glyph are skipped, the advance still uses fw
          n = (fw > MAX_GLYPH_W) ? MAX_GLYPH_W : fw;
          for (j = 0; j < n; j++)
            void'(plot(shadow_cur_x + j, shadow_cur_y + it.row_index,
                       it.row_bits[15 - j] ? it.color : !it.color));
          if (it.last_row) shadow_cur_x = shadow_cur_x + shadow_cfg.font_width;
          r.accepted = 1'b1;
        end
      end
      MODE_CURSOR: begin
        shadow_cur_x = it.pos_x;
        shadow_cur_y = it.pos_y;
        r.accepted = 1'b1;
      end
      MODE_READ: begin
        if (it.read_index < STORE_BYTES) begin
          r.read_data = shadow_fb[it.read_index];
          r.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic req_t req_beat(input logic [2:0] m, input logic [7:0] x,
                                    input logic [7:0] y, input logic c,
                                    input logic [15:0] bits, input logic [4:0] ridx,
                                    input logic last, input logic [9:0] raddr);
    req_t it;
    it.mode = m;
    it.pos_x = x;
    it.pos_y = y;
    it.color = c;
    it.row_bits = bits;
    it.row_index = ridx;
    it.last_row = last;
    it.read_index = raddr;
    return it;
  endfunction

  function automatic req_t rand_beat(input logic [2:0] m);
    logic [63:0] raw;
    req_t        it;
    raw = {$urandom, $urandom};
    it = raw[$bits(req_t)-1:0];
    it.mode = m;
    return it;
  endfunction

  function automatic void add_item(input req_t it);
    plan_row_t r;
    r = '{default: '0};
    r.item = it;
    plan.push_back(r);
  endfunction

  function automatic void add_typed(input req_t it, input logic [7:0] d, input logic a);
    plan_row_t r;
    r = '{default: '0};
    r.item = it;
    r.typed = 1'b1;
    r.want.read_data = d;
    r.want.accepted = a;
    plan.push_back(r);
  endfunction

  function automatic void add_reg(input logic [1:0] idx, input logic [7:0] v);
    plan_row_t r;
    r = '{default: '0};
    r.reg_write = 1'b1;
    r.reg_idx = idx;
    r.reg_val = v;
    plan.push_back(r);
  endfunction

  // all tasks below start and end at a falling edge
  task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
    cfg_index = idx;
    cfg_wdata = v;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_DISPLAY_WIDTH:  shadow_cfg.display_width = v;
      REG_DISPLAY_HEIGHT: shadow_cfg.display_height = v[6:0];
      REG_FONT_WIDTH:     shadow_cfg.font_width = v[4:0];
      REG_FONT_HEIGHT:    shadow_cfg.font_height = v[5:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    req_valid = 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic set_config(input logic [7:0] w, input logic [7:0] h,
                            input logic [7:0] fw, input logic [7:0] fh);
    wait_idle();
    write_reg(REG_DISPLAY_WIDTH, w);
    write_reg(REG_DISPLAY_HEIGHT, h);
    write_reg(REG_FONT_WIDTH, fw);
    write_reg(REG_FONT_HEIGHT, fh);
  endtask

  task automatic send(input req_t it, input bit typed, input rsp_t want);
    int   gap;
    rsp_t guess;
    gap = calm_tx ? 0 : $urandom_range(0, 3);
    if ($urandom_range(0, 39) == 0) calm_tx = !calm_tx;
    if (gap > 0) begin
      req_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req = it;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    guess = apply_draw_item(it);
    pending_rsp.push_back(typed ? want : guess);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic run_random(input int budget);
    int   stop_at;
    int   pick;
    int   w;
    int   h;
    int   fw;
    int   fh;
    int   n;
    int   cx;
    int   cy;
    int   rows;
    int   k;
    int   x;
    int   y;
    logic c;
    req_t it;
    stop_at = sent_items + budget;
    while (sent_items < stop_at) begin
      w = shadow_cfg.display_width;
      h = shadow_cfg.display_height;
      fw = shadow_cfg.font_width;
      fh = shadow_cfg.font_height;
      n = (w * h) / 8;
      if (n > STORE_BYTES) n = STORE_BYTES;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        // whole glyph: cursor set, its rows, then a few bytes under it
        if ($urandom_range(0, 4) != 0 && w > fw && h > fh) begin
          cx = $urandom_range(0, w - fw - 1);
          cy = $urandom_range(0, h - fh - 1);
        end else begin
          cx = $urandom_range(0, 255);
          cy = $urandom_range(0, 255);
        end
        it = rand_beat(MODE_CURSOR);
        it.pos_x = 8'(cx);
        it.pos_y = 8'(cy);
        send(it, 1'b0, '0);
        rows = (fh == 0) ? 1 : fh;
        c = 1'($urandom_range(0, 1));
        for (k = 0; k < rows; k++) begin
          it = rand_beat(MODE_GLYPH);
          it.color = c;
          it.row_index = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'(k);
          it.last_row = (k == rows - 1);
          send(it, 1'b0, '0);
        end
        for (k = 0; k < 3; k++) begin
          x = cx + $urandom_range(0, fw);
          y = cy + $urandom_range(0, fh);
          it = rand_beat(MODE_READ);
          it.read_index = 10'(x + (y / 8) * w);
          send(it, 1'b0, '0);
        end
      end else if (pick < 55) begin
        it = rand_beat(MODE_PIXEL);
        if ($urandom_range(0, 4) != 0 && w > 0 && h > 0) begin
          it.pos_x = 8'($urandom_range(0, w - 1));
          it.pos_y = 8'($urandom_range(0, h - 1));
        end
        send(it, 1'b0, '0);
      end else if (pick < 87) begin
        it = rand_beat(MODE_READ);
        if ($urandom_range(0, 3) != 0 && n > 0) it.read_index = 10'($urandom_range(0, n - 1));
        send(it, 1'b0, '0);
      end else if (pick < 89) begin
        send(rand_beat(MODE_FILL), 1'b0, '0);
      end else if (pick < 94) begin
        send(rand_beat(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST))), 1'b0, '0);
      end else if (pick < 99) begin
        send(rand_beat(MODE_CURSOR), 1'b0, '0);
      end else begin
        wait_idle();
      end
    end
  endtask

  initial begin
    int   stall;
    rsp_t want;
    while (rst) @(negedge clk);
    forever begin
      stall = calm_rx ? 0 : $urandom_range(0, 3);
      if ($urandom_range(0, 39) == 0) calm_rx = !calm_rx;
      if (stall > 0) begin
        rsp_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready = 1'b1;
      do @(posedge clk); while (!rsp_valid);
      if (pending_rsp.size() == 0) begin
        $error("response beat with nothing pending");
        err_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.read_data !== want.read_data) begin
          $error("read_data mismatch: expected %0h, actual %0h", want.read_data, rsp.read_data);
          err_count++;
        end
        if (rsp.accepted !== want.accepted) begin
          $error("accepted mismatch: expected %0h, actual %0h", want.accepted, rsp.accepted);
          err_count++;
        end
      end
      @(negedge clk);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    foreach (shadow_fb[i]) shadow_fb[i] = BYTE_ZERO;
    shadow_cur_x = '0;
    shadow_cur_y = '0;
    shadow_cfg.display_width = 8'd128;
    shadow_cfg.display_height = 7'd64;
    shadow_cfg.font_width = 5'd7;
    shadow_cfg.font_height = 6'd10;

    // reset register values: store cleared, pixel corners, bounds
    add_typed(req_beat(MODE_READ, 8'h00, 8'h00, 1'b0, 16'h0000, 5'd0, 1'b0, 10'd1023),
              BYTE_ZERO, 1'b1);
    add_typed(req_beat(MODE_PIXEL, 8'd0, 8'd0, 1'b1, 16'h0000, 5'd0, 1'b0, 10'd0),
              BYTE_ZERO, 1'b1);
    add_typed(req_beat(MODE_READ, 8'h00, 8'h00, 1'b0, 16'h0000, 5'd0, 1'b0, 10'd0),
              8'h01, 1'b1);
    add_typed(req_beat(MODE_PIXEL, 8'd127, 8'd63, 1'b1, 16'h0000, 5'd0, 1'b0, 10'd0),
              BYTE_ZERO, 1'b1);
    add_typed(req_beat(MODE_READ, 8'h00, 8'h00, 1'b0, 16'h0000, 5'd0, 1'b0, 10'd1023),
              8'h80, 1'b1);
    add_typed(req_beat(MODE_PIXEL, 8'd128, 8'd0, 1'b1, 16'h0000, 5'd0, 1'b0, 10'd0),
              BYTE_ZERO, 1'b0);
    add_typed(req_beat(MODE_PIXEL, 8'd255, 8'd255, 1'b0, 16'hFFFF, 5'd31, 1'b1, 10'd1023),
              BYTE_ZERO, 1'b0);
    // glyph inside the display, then a row past its height
    add_typed(req_beat(MODE_CURSOR, 8'd2, 8'd3, 1'b0, 16'h0000, 5'd0, 1'b0, 10'd0),
              BYTE_ZERO, 1'b1);
    add_item(req_beat(MODE_GLYPH, 8'd0, 8'd0, 1'b1, 16'hA5C3, 5'd0, 1'b0, 10'd0));
    add_item(req_beat(MODE_GLYPH, 8'd0, 8'd0, 1'b1, 16'h5A3C, 5'd9, 1'b1, 10'd0));
    add_typed(req_beat(MODE_GLYPH, 8'd0, 8'd0, 1'b1, 16'hFFFF, 5'd10, 1'b1, 10'd0),
              BYTE_ZERO, 1'b0);
    add_item(req_beat(MODE_READ, 8'h00, 8'h00, 1'b0, 16'h0000, 5'd0, 1'b0, 10'd2));
    // glyph reaching the right edge does not fit
    add_typed(req_beat(MODE_CURSOR, 8'd121, 8'd0, 1'b0, 16'h0000, 5'd0, 1'b0, 10'd0),
              BYTE_ZERO, 1'b1);
    add_typed(req_beat(MODE_GLYPH, 8'd0, 8'd0, 1'b1, 16'hFFFF, 5'd0, 1'b1, 10'd0),
              BYTE_ZERO, 1'b0);
    add_typed(req_beat(MODE_FILL, 8'd0, 8'd0, 1'b1, 16'h0000, 5'd0, 1'b0, 10'd0),
              BYTE_ZERO, 1'b1);
    add_typed(req_beat(MODE_READ, 8'h00, 8'h00, 1'b0, 16'h0000, 5'd0, 1'b0, 10'd1023),
              BYTE_ONES, 1'b1);
    add_typed(req_beat(MODE_SPARE_FIRST, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 5'd31, 1'b1, 10'd1023),
              BYTE_ZERO, 1'b0);
    // oversized display: fill capped at the store, pages beyond the store, wide font
    add_reg(REG_DISPLAY_WIDTH, 8'd200);
    add_reg(REG_DISPLAY_HEIGHT, 8'd100);
    add_reg(REG_FONT_WIDTH, 8'd20);
    add_reg(REG_FONT_HEIGHT, 8'd5);
    add_typed(req_beat(MODE_FILL, 8'd0, 8'd0, 1'b0, 16'h0000, 5'd0, 1'b0, 10'd0),
              BYTE_ZERO, 1'b1);
    add_typed(req_beat(MODE_FILL, 8'd0, 8'd0, 1'b1, 16'h0000, 5'd0, 1'b0, 10'd0),
              BYTE_ZERO, 1'b1);
    add_typed(req_beat(MODE_READ, 8'h00, 8'h00, 1'b0, 16'h0000, 5'd0, 1'b0, 10'd1023),
              BYTE_ONES, 1'b1);
    add_typed(req_beat(MODE_PIXEL, 8'd199, 8'd99, 1'b0, 16'h0000, 5'd0, 1'b0, 10'd0),
              BYTE_ZERO, 1'b0);
    add_typed(req_beat(MODE_PIXEL, 8'd199, 8'd7, 1'b0, 16'h0000, 5'd0, 1'b0, 10'd0),
              BYTE_ZERO, 1'b1);
    add_typed(req_beat(MODE_CURSOR, 8'd10, 8'd10, 1'b0, 16'h0000, 5'd0, 1'b0, 10'd0),
              BYTE_ZERO, 1'b1);
    add_item(req_beat(MODE_GLYPH, 8'd0, 8'd0, 1'b1, 16'h8001, 5'd0, 1'b1, 10'd0));
    add_item(req_beat(MODE_READ, 8'h00, 8'h00, 1'b0, 16'h0000, 5'd0, 1'b0, 10'd210));
    add_item(req_beat(MODE_READ, 8'h00, 8'h00, 1'b0, 16'h0000, 5'd0, 1'b0, 10'd226));

    repeat (6) @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].reg_write) begin
        wait_idle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    set_config(8'd128, 8'd64, 8'd7, 8'd10);
    run_random(PHASE_ITEMS);
    set_config(8'd1, 8'd8, 8'd1, 8'd1);
    run_random(PHASE_ITEMS);
    set_config(8'd128, 8'd64, 8'd16, 8'd32);
    run_random(PHASE_ITEMS);
    set_config(8'd255, 8'd127, 8'd31, 8'd63);
    run_random(PHASE_ITEMS);
    set_config(8'd200, 8'd100, 8'd20, 8'd5);
    run_random(PHASE_ITEMS);
    set_config(8'd64, 8'd32, 8'd5, 8'd8);
    run_random(PHASE_ITEMS);
    repeat (3) begin
      set_config(8'($urandom_range(1, 128)), 8'(8 * $urandom_range(1, 8)),
                 8'($urandom_range(1, 16)), 8'($urandom_range(1, 32)));
      run_random(PHASE_ITEMS);
    end

    wait_idle();
    // catch any stray beat after the last expected one
    repeat (40) @(negedge clk);
    if (err_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+hdl
hdl/pfde_pkg.sv
hdl/pfde_store.sv
hdl/pfde_ctrl.sv
hdl/page_framebuffer_draw_engine.sv
bench/page_framebuffer_draw_engine_test.sv
